// File: design/cdd_pkg.sv
// Shared types, constants and calendar helpers for the date decrementer.
// No dependencies; used by cdd_step and calendar_date_decrementer.
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned DAYS_PER_WEEK   = 7;
  localparam int unsigned RED_STEPS       = 6;   // 400 << 5 .. 400 << 0

  localparam logic [2:0] MODE_DAYS       = 3'd0;
  localparam logic [2:0] MODE_WEEKS      = 3'd1;
  localparam logic [2:0] MODE_MONTHS     = 3'd2;
  localparam logic [2:0] MODE_YEARS      = 3'd3;
  localparam logic [2:0] MODE_FAST_YEARS = 3'd4;

  typedef struct packed {
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
    logic [2:0]  mode;
    logic [15:0] count;
  } cdd_req_t;

  typedef struct packed {
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic        underflow;
  } cdd_rsp_t;

  // working date; yrem tracks year mod 400
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [8:0]  yrem;
  } cdd_date_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DAY,
    OP_MONTH,
    OP_YEAR
  } cdd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CLAMP,
    ST_RUN,
    ST_DONE
  } cdd_state_t;

  function automatic logic is_leap(input logic [8:0] yrem);
    is_leap = (yrem[1:0] == 2'd0) && (yrem != 9'd100) && (yrem != 9'd200) &&
              (yrem != 9'd300);
  endfunction

  function automatic logic [8:0] rem_dec(input logic [8:0] yrem);
    rem_dec = (yrem == 9'd0) ? 9'd399 : yrem - 9'd1;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    case (month)
      4'd2:                      days_in = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days_in = 5'd30;
      default:                   days_in = 5'd31;
    endcase
  endfunction

  // 400 shifted for the mod-400 reduction, one compare/subtract per cycle
  function automatic logic [13:0] red_const(input logic [2:0] k);
    red_const = 14'(14'd400 << k);
  endfunction

endpackage

// File: design/calendar_date_decrementer.sv
// Gregorian date decrementer: top level with sequencer around cdd_step.
// Depends on cdd_pkg and cdd_step.
// Sequence: reduce the year mod 400, clamp the day, then run S elementary steps, S =
//   count, 7*count, count, 12*count or 2*count for modes 0..4 (fewer on underflow);
//   year 0 and modes 5..7 skip them. A new request waits until the response is taken.
// Reset (rst, synchronous) returns the sequencer to idle and drops rsp_valid.
`timescale 1ns / 1ps

module calendar_date_decrementer (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cdd_pkg::cdd_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output cdd_pkg::cdd_rsp_t rsp
);
  import cdd_pkg::*;

  cdd_state_t  state, state_next;
  cdd_date_t   date;
  cdd_date_t   step_date;
  logic        step_ok;
  cdd_op_t     op;
  logic [13:0] rem;
  logic [2:0]  red_k;
  logic [15:0] units;
  logic [3:0]  sub_idx;
  logic [3:0]  sub_last;
  logic [2:0]  mode;
  logic        uf;
  logic        fail;
  logic [4:0]  lim;

  cdd_step u_step (
    .op  (op),
    .cur (date),
    .nxt (step_date),
    .ok  (step_ok)
  );

  always_comb begin
    case (mode)
      MODE_WEEKS:      sub_last = 4'(DAYS_PER_WEEK - 1);
      MODE_YEARS:      sub_last = 4'(MONTHS_PER_YEAR - 1);
      MODE_FAST_YEARS: sub_last = 4'd1;
      default:         sub_last = 4'd0;
    endcase
  end

  // fast year: phase 0 steps back a day if the previous year is leap, phase 1 drops the year
  always_comb begin
    case (mode)
      MODE_DAYS, MODE_WEEKS:   op = OP_DAY;
      MODE_MONTHS, MODE_YEARS: op = OP_MONTH;
      MODE_FAST_YEARS: begin
        if (sub_idx == 4'd0) begin
          op = is_leap(rem_dec(date.yrem)) ? OP_DAY : OP_NONE;
        end else begin
          op = OP_YEAR;
        end
      end
      default:                 op = OP_NONE;
    endcase
  end

  assign fail = ((mode == MODE_FAST_YEARS) && (sub_idx == 4'd0) && (date.year <= 14'd1)) ||
                !step_ok;
  assign lim  = days_in(date.month, is_leap(date.yrem));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_k == 3'd0) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if ((date.year == 14'd0) || (mode > MODE_FAST_YEARS)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((units == 16'd0) || fail) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req_ready     = (state == ST_IDLE);
    rsp_valid     = (state == ST_DONE);
    rsp.day_out   = date.day;
    rsp.month_out = date.month;
    rsp.year_out  = date.year;
    rsp.underflow = uf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          date.day   <= (req.day_in == 5'd0) ? 5'd1 : req.day_in;
          date.month <= (req.month_in == 4'd0) ? 4'd1 :
                        (req.month_in > 4'(MONTHS_PER_YEAR)) ? 4'(MONTHS_PER_YEAR) :
                        req.month_in;
          date.year  <= req.year_in;
          rem        <= req.year_in;
          red_k      <= 3'(RED_STEPS - 1);
          mode       <= req.mode;
          units      <= req.count;
          sub_idx    <= 4'd0;
          uf         <= 1'b0;
        end
      end
      ST_REDUCE: begin
        if (rem >= red_const(red_k)) begin
          rem <= rem - red_const(red_k);
        end
        red_k <= red_k - 3'd1;
        if (red_k == 3'd0) begin
          date.yrem <= (rem >= red_const(red_k)) ? 9'(rem - red_const(red_k)) : rem[8:0];
        end
      end
      ST_CLAMP: begin
        if (date.day > lim) begin
          date.day <= lim;
        end
        if (date.year == 14'd0) begin
          uf <= 1'b1;
        end
      end
      ST_RUN: begin
        if (units != 16'd0) begin
          if (fail) begin
            uf <= 1'b1;
          end else begin
            date <= step_date;
            if (sub_idx == sub_last) begin
              sub_idx <= 4'd0;
              units   <= units - 16'd1;
            end else begin
              sub_idx <= sub_idx + 4'd1;
            end
          end
        end
      end
      default: begin
        date <= date;
      end
    endcase
  end

endmodule

// File: design/cdd_step.sv
// One elementary calendar step: day back, month back or year back with clamp.
// Depends on cdd_pkg. Purely combinational; the sequencer registers the result.
`timescale 1ns / 1ps

module cdd_step (
  input  cdd_pkg::cdd_op_t   op,
  input  cdd_pkg::cdd_date_t cur,
  output cdd_pkg::cdd_date_t nxt,
  output logic               ok
);
  import cdd_pkg::*;

  logic [8:0]  rem_m1;
  logic [13:0] year_m1;
  logic [3:0]  mon_t;
  logic [4:0]  lim;

  assign rem_m1  = rem_dec(cur.yrem);
  assign year_m1 = cur.year - 14'd1;

  always_comb begin
    nxt   = cur;
    ok    = 1'b1;
    mon_t = cur.month;
    lim   = 5'd31;
    case (op)
      OP_DAY: begin
        if (cur.day > 5'd1) begin
          nxt.day = cur.day - 5'd1;
        end else if (cur.month > 4'd1) begin
          mon_t     = cur.month - 4'd1;
          nxt.month = mon_t;
          nxt.day   = days_in(mon_t, is_leap(cur.yrem));
        end else if (cur.year <= 14'd1) begin
          ok = 1'b0;
        end else begin
          nxt.year  = year_m1;
          nxt.yrem  = rem_m1;
          nxt.month = 4'(MONTHS_PER_YEAR);
          nxt.day   = 5'd31;
        end
      end
      OP_MONTH: begin
        if (cur.month > 4'd1) begin
          nxt.month = cur.month - 4'd1;
          lim       = days_in(nxt.month, is_leap(cur.yrem));
        end else if (cur.year <= 14'd1) begin
          ok = 1'b0;
        end else begin
          nxt.year  = year_m1;
          nxt.yrem  = rem_m1;
          nxt.month = 4'(MONTHS_PER_YEAR);
          lim       = 5'd31;
        end
        if (ok && (cur.day > lim)) begin
          nxt.day = lim;
        end
      end
      OP_YEAR: begin
        nxt.year = year_m1;
        nxt.yrem = rem_m1;
        lim      = days_in(cur.month, is_leap(rem_m1));
        if (cur.day > lim) begin
          nxt.day = lim;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
